// ===== rtl/pkfm_pkg.sv =====
// ----------------------------------------------------------------------------
// pkfm_pkg: shared types and constants of the PK font metrics parser
// Byte and record layouts, record kinds, parse phases and preamble tables.
// ----------------------------------------------------------------------------
package pkfm_pkg;

  localparam int unsigned CharCount = 256;
  localparam int unsigned RecFields = 9;

  // Command bytes of the PK format
  localparam logic [7:0] CmdPre  = 8'd247;
  localparam logic [7:0] CmdId   = 8'd89;
  localparam logic [7:0] CmdXxx1 = 8'd240;
  localparam logic [7:0] CmdXxx4 = 8'd243;
  localparam logic [7:0] CmdYyy  = 8'd244;
  localparam logic [7:0] CmdPost = 8'd245;
  localparam logic [7:0] CmdNop  = 8'd246;

  // Configuration register indexes
  localparam logic CfgFontScale = 1'b0;
  localparam logic CfgExpChksum = 1'b1;

  typedef enum logic [2:0] {
    KindHeader   = 3'd0,
    KindChar     = 3'd1,
    KindEnd      = 3'd2,
    KindBadPre   = 3'd3,
    KindBadId    = 3'd4,
    KindCharBig  = 3'd5,
    KindBadSpec  = 3'd6
  } kind_e;

  typedef enum logic [3:0] {
    PhPre,
    PhId,
    PhClen,
    PhCskip,
    PhHdr,
    PhSpec,
    PhXlen,
    PhSkip,
    PhChar,
    PhDone
  } phase_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       file_start;
  } pkfm_in_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic [7:0]         char_code;
    logic [31:0]        tfm_width;
    logic signed [31:0] escape_x;
    logic signed [31:0] escape_y;
    logic [15:0]        pixel_width;
    logic [31:0]        glyph_width;
    logic [31:0]        glyph_height;
    logic signed [31:0] offset_x;
    logic signed [31:0] offset_y;
    logic [31:0]        packet_offset;
    logic               checksum_mismatch;
  } pkfm_out_t;

  // Bytes per preamble item: length, code, tfm, dx, dy, w, h, hoff, voff
  function automatic logic [2:0] item_width(input logic [1:0] form, input logic [3:0] item);
    logic [2:0] w;
    w = 3'd4;
    if (form != 2'd2) begin
      case (item)
        4'd2:    w = 3'd3;
        4'd4:    w = 3'd0;
        default: w = (form == 2'd0) ? 3'd1 : 3'd2;
      endcase
      if (item == 4'd1) w = 3'd1;
    end
    return w;
  endfunction

  function automatic logic item_signed(input logic [1:0] form, input logic [3:0] item);
    logic s;
    case (item)
      4'd3, 4'd4: s = (form == 2'd2);
      4'd7, 4'd8: s = 1'b1;
      default:    s = 1'b0;
    endcase
    return s;
  endfunction

  function automatic logic [31:0] bytes_after_code(input logic [1:0] form);
    logic [31:0] n;
    case (form)
      2'd0:    n = 32'd8;
      2'd1:    n = 32'd13;
      default: n = 32'd28;
    endcase
    return n;
  endfunction

endpackage

// ===== rtl/pk_font_metrics_parser_top.sv =====
// ----------------------------------------------------------------------------
// pk_font_metrics_parser_top: PK font file metrics parser
// Parses a PK font byte stream into header, metrics, end and error records.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  in      | input     | in_valid_i/in_stall_o  | in_data_i  (pkfm_in_t)
//  out     | output    | out_valid_o/out_stall_i| out_data_o (pkfm_out_t)
//  cfg     | input     | cfg_we_i               | cfg_idx_i, cfg_wdata_i
//
// One byte is taken per cycle unless the input stalls; its record, if any, is registered into an output entry.
// The record path holds one 32x32 multiply for the scaled TFM width.
// A two-entry output buffer keeps input flowing while one record waits.
// Reset returns the parser to waiting for the pre byte, both registers zero.
// Input stalls only while both output entries hold records.
module pk_font_metrics_parser_top
  import pkfm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  pkfm_in_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output pkfm_out_t   out_data_o,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_wdata_i
);

  logic [31:0] scale_q, chk_q;
  phase_e      ph_q, ph_d, ph_c;
  logic [3:0]  idx_q, idx_d, idx_c;
  logic [2:0]  cnt_q, cnt_d, cnt_c;
  logic [31:0] acc_q, acc_d, acc_c;
  logic [31:0] skip_q, skip_d, skip_c;
  logic [31:0] pos_q, pos_d, pos_c;
  logic [31:0] pst_q, pst_d, pst_c;
  logic [1:0]  form_q, form_d, form_c;
  logic [31:0] rf_q [RecFields];
  logic [31:0] rf_d [RecFields];
  logic [31:0] rf_c [RecFields];

  logic        accept, emit, pop;
  pkfm_out_t   rec;
  logic [7:0]  b;
  logic [2:0]  cnt_n, w;
  logic [31:0] acc_n, v, used;
  logic [63:0] prod;
  logic [32:0] px_sum;

  logic        out_valid_q, skid_valid_q;
  pkfm_out_t   out_q, skid_q;

  assign in_stall_o  = skid_valid_q;
  assign accept      = in_valid_i & ~skid_valid_q;
  assign pop         = out_valid_q & ~out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= '0;
      chk_q   <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CfgFontScale) scale_q <= cfg_wdata_i;
      if (cfg_idx_i == CfgExpChksum) chk_q   <= cfg_wdata_i;
    end
  end

  // Current state, cleared at the first byte of a new file
  always_comb begin
    ph_c   = in_data_i.file_start ? PhPre : ph_q;
    idx_c  = in_data_i.file_start ? '0 : idx_q;
    cnt_c  = in_data_i.file_start ? '0 : cnt_q;
    acc_c  = in_data_i.file_start ? '0 : acc_q;
    skip_c = in_data_i.file_start ? '0 : skip_q;
    pos_c  = in_data_i.file_start ? '0 : pos_q;
    pst_c  = in_data_i.file_start ? '0 : pst_q;
    form_c = in_data_i.file_start ? '0 : form_q;
    for (int i = 0; i < RecFields; i++) rf_c[i] = in_data_i.file_start ? '0 : rf_q[i];
  end

  assign b     = in_data_i.data_byte;
  assign acc_n = {acc_c[23:0], b};
  assign cnt_n = cnt_c + 3'd1;
  assign w     = item_width(form_c, idx_c);

  // Sign-extend, scale and sum the preamble item that completes
  always_comb begin
    v = acc_n;
    if (item_signed(form_c, idx_c)) begin
      case (w)
        3'd1:    v = {{24{acc_n[7]}}, acc_n[7:0]};
        3'd2:    v = {{16{acc_n[15]}}, acc_n[15:0]};
        3'd3:    v = {{8{acc_n[23]}}, acc_n[23:0]};
        default: v = acc_n;
      endcase
    end
    if (idx_c == 4'd3 && form_c != 2'd2) v = {v[15:0], 16'd0};
    if (idx_c == 4'd0) v = v + rf_c[0];
  end

  assign used   = bytes_after_code(form_c);
  assign prod   = 64'(rf_c[2]) * 64'(scale_q);
  assign px_sum = 33'(rf_c[3]) + 33'd32768;

  // Parse one byte
  always_comb begin
    ph_d   = ph_c;
    idx_d  = idx_c;
    cnt_d  = cnt_c;
    acc_d  = acc_c;
    skip_d = skip_c;
    pos_d  = pos_c + 32'd1;
    pst_d  = pst_c;
    form_d = form_c;
    for (int i = 0; i < RecFields; i++) rf_d[i] = rf_c[i];
    emit = 1'b0;
    rec  = '0;
    case (ph_c)
      PhPre: begin
        if (b == CmdPre) ph_d = PhId;
        else begin
          emit = 1'b1; rec.kind = KindBadPre; ph_d = PhDone;
        end
      end
      PhId: begin
        if (b == CmdId) ph_d = PhClen;
        else begin
          emit = 1'b1; rec.kind = KindBadId; ph_d = PhDone;
        end
      end
      PhClen: begin
        skip_d = 32'(b);
        idx_d  = '0;
        ph_d   = (b != 8'd0) ? PhCskip : PhHdr;
      end
      PhCskip: begin
        skip_d = skip_c - 32'd1;
        idx_d  = '0;
        if (skip_d == '0) ph_d = PhHdr;
      end
      PhHdr: begin
        acc_d = acc_n;
        cnt_d = cnt_n;
        if (cnt_n == 3'd4) begin
          acc_d = '0;
          cnt_d = '0;
          if (idx_c < 4'd3) begin
            rf_d[idx_c] = acc_n;
            idx_d = idx_c + 4'd1;
          end else begin
            emit = 1'b1;
            rec.kind      = KindHeader;
            rec.tfm_width = rf_c[0];
            rec.escape_x  = rf_c[2];
            rec.escape_y  = acc_n;
            rec.checksum_mismatch = (chk_q != '0) && (rf_c[1] != '0) && (chk_q != rf_c[1]);
            ph_d = PhSpec;
          end
        end
      end
      PhSpec: begin
        if (b < CmdXxx1) begin
          for (int i = 0; i < RecFields; i++) rf_d[i] = '0;
          form_d = (b[2:0] < 3'd4) ? 2'd0 : ((b[2:0] < 3'd7) ? 2'd1 : 2'd2);
          if (form_d == 2'd0) rf_d[0] = {22'd0, b[1:0], 8'd0};
          else if (form_d == 2'd1) rf_d[0] = {14'd0, b[1:0], 16'd0};
          pst_d = pos_c;
          acc_d = '0;
          cnt_d = '0;
          idx_d = '0;
          ph_d  = PhChar;
        end else if (b <= CmdXxx4) begin
          form_d = b[1:0];
          acc_d  = '0;
          cnt_d  = '0;
          ph_d   = PhXlen;
        end else if (b == CmdYyy) begin
          skip_d = 32'd4;
          ph_d   = PhSkip;
        end else if (b == CmdPost) begin
          emit = 1'b1; rec.kind = KindEnd; ph_d = PhDone;
        end else if (b != CmdNop) begin
          emit = 1'b1; rec.kind = KindBadSpec; ph_d = PhDone;
        end
      end
      PhXlen: begin
        acc_d = acc_n;
        cnt_d = cnt_n;
        if (cnt_n == 3'({1'b0, form_c} + 3'd1)) begin
          skip_d = acc_n;
          acc_d  = '0;
          cnt_d  = '0;
          ph_d   = (acc_n != '0) ? PhSkip : PhSpec;
        end
      end
      PhSkip: begin
        skip_d = skip_c - 32'd1;
        if (skip_d == '0) ph_d = PhSpec;
      end
      PhChar: begin
        acc_d = acc_n;
        cnt_d = cnt_n;
        if (cnt_n >= w) begin
          acc_d = '0;
          cnt_d = '0;
          rf_d[idx_c] = v;
          if (idx_c == 4'd1 && v[31:8] != '0) begin
            emit = 1'b1; rec.kind = KindCharBig; ph_d = PhDone;
          end else if (idx_c == 4'd3 && form_c != 2'd2) begin
            idx_d = 4'd5;
          end else if (idx_c != 4'd8) begin
            idx_d = idx_c + 4'd1;
          end else begin
            // Last item: emit the metrics record, then skip the raster
            skip_d = (rf_c[0] > used) ? rf_c[0] - used : '0;
            ph_d   = (skip_d != '0) ? PhSkip : PhSpec;
            emit   = 1'b1;
            rec.kind          = KindChar;
            rec.char_code     = rf_c[1][7:0];
            rec.tfm_width     = (prod[63:52] != '0) ? '1 : prod[51:20];
            rec.escape_x      = rf_c[3];
            rec.escape_y      = rf_c[4];
            rec.pixel_width   = px_sum[31:16];
            rec.glyph_width   = rf_c[5];
            rec.glyph_height  = rf_c[6];
            rec.offset_x      = rf_c[7];
            rec.offset_y      = v;
            rec.packet_offset = pst_c;
          end
        end
      end
      default: ;
    endcase
  end

  // Parser state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= PhPre;
      idx_q  <= '0;
      cnt_q  <= '0;
      acc_q  <= '0;
      skip_q <= '0;
      pos_q  <= '0;
      pst_q  <= '0;
      form_q <= '0;
      for (int i = 0; i < RecFields; i++) rf_q[i] <= '0;
    end else if (accept) begin
      ph_q   <= ph_d;
      idx_q  <= idx_d;
      cnt_q  <= cnt_d;
      acc_q  <= acc_d;
      skip_q <= skip_d;
      pos_q  <= pos_d;
      pst_q  <= pst_d;
      form_q <= form_d;
      for (int i = 0; i < RecFields; i++) rf_q[i] <= rf_d[i];
    end
  end

  // Output register with one skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end
    end else if (accept && emit) begin
      if (!out_valid_q || pop) out_valid_q <= 1'b1;
      else skid_valid_q <= 1'b1;
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  // Hold record payloads
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) out_q <= skid_q;
    end else if (accept && emit) begin
      if (!out_valid_q || pop) out_q <= rec;
      else skid_q <= rec;
    end
  end

endmodule

// ===== rtl/pkfm_checker.sv =====
// ----------------------------------------------------------------------------
// pkfm_checker: port checks of the PK font metrics parser
// Watches the top level ports and reports protocol and record slips.
// ----------------------------------------------------------------------------
module pkfm_checker
  import pkfm_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input pkfm_in_t    in_data_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input pkfm_out_t   out_data_o,
  input logic        cfg_we_i,
  input logic        cfg_idx_i,
  input logic [31:0] cfg_wdata_i
);

  // Hold a stalled record
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled record dropped or changed");

  // Stall input only while a record is pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output");

  // Input stall only after an output stall
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(out_stall_i))
    else $error("input stall without output stall");

  // Only header records carry the checksum flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.checksum_mismatch |-> out_data_o.kind == KindHeader)
    else $error("checksum flag on non-header record");

endmodule

bind pk_font_metrics_parser_top pkfm_checker u_pkfm_checker (.*);

// ===== test/pk_font_metrics_parser_top_tb.sv =====
// ----------------------------------------------------------------------------
// pk_font_metrics_parser_top_tb: self-checking bench for the PK metrics parser
// Streams generated PK font files (well-formed, broken and noisy) through the
// byte channel, predicts every record in lockstep and compares each transfer.
// ----------------------------------------------------------------------------
module pk_font_metrics_parser_top_tb;
  import pkfm_pkg::*;

  localparam int unsigned CycleLimit = 600000;

  // Preamble layout per form: length, code, tfm, dx, dy, w, h, hoff, voff
  localparam int unsigned ItemBytes [3][9] = '{
    '{1, 1, 3, 1, 0, 1, 1, 1, 1},
    '{2, 1, 3, 2, 0, 2, 2, 2, 2},
    '{4, 4, 4, 4, 4, 4, 4, 4, 4}
  };
  localparam bit ItemSigned [3][9] = '{
    '{0, 0, 0, 0, 0, 0, 0, 1, 1},
    '{0, 0, 0, 0, 0, 0, 0, 1, 1},
    '{0, 0, 0, 1, 1, 0, 0, 1, 1}
  };
  localparam int unsigned PreambleTail [3] = '{8, 13, 28};

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  pkfm_in_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  pkfm_out_t   out_data;
  logic        cfg_we = 1'b0;
  logic        cfg_idx = CfgFontScale;
  logic [31:0] cfg_wdata = '0;

  pk_font_metrics_parser_top u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  // Shadow parser state
  logic [31:0] scale_reg, dvi_chksum;
  phase_e      phase;
  int unsigned sub_item;
  logic [2:0]  byte_cnt;
  logic [31:0] accum, skip_left, file_pos, pkt_start;
  logic [1:0]  form;
  logic [31:0] fields [9];

  pkfm_out_t   record_q [$];
  logic [7:0]  file_q [$];
  int unsigned errors, bytes_sent, records_seen, gap_pct, stall_pct, cycles;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Bound the run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("[pk_font_metrics_parser_top] ERROR");
      $finish;
    end
  end

  // Drive output stall: mostly short bursts, a few long ones
  int unsigned stall_left;
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s expected %h got %h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  // Compare each output transfer with the oldest predicted record
  always @(posedge clk_i) begin
    pkfm_out_t e;
    if (rst_ni && out_valid && !out_stall) begin
      records_seen++;
      if (record_q.size() == 0) begin
        $display("%0t: unexpected record, kind %0d", $time, out_data.kind);
        errors++;
      end else begin
        e = record_q.pop_front();
        check_field("kind", e.kind, out_data.kind);
        check_field("char_code", e.char_code, out_data.char_code);
        check_field("tfm_width", e.tfm_width, out_data.tfm_width);
        check_field("escape_x", e.escape_x, out_data.escape_x);
        check_field("escape_y", e.escape_y, out_data.escape_y);
        check_field("pixel_width", e.pixel_width, out_data.pixel_width);
        check_field("glyph_width", e.glyph_width, out_data.glyph_width);
        check_field("glyph_height", e.glyph_height, out_data.glyph_height);
        check_field("offset_x", e.offset_x, out_data.offset_x);
        check_field("offset_y", e.offset_y, out_data.offset_y);
        check_field("packet_offset", e.packet_offset, out_data.packet_offset);
        check_field("checksum_mismatch", e.checksum_mismatch, out_data.checksum_mismatch);
      end
    end
  end

  task automatic clear_parse();
    phase = PhPre;
    sub_item = 0;
    byte_cnt = '0;
    accum = '0;
    skip_left = '0;
    file_pos = '0;
    pkt_start = '0;
    form = '0;
    foreach (fields[i]) fields[i] = '0;
  endtask

  // Advance the shadow parser by one accepted byte
  task automatic parse_byte(input logic [7:0] b, input logic start);
    pkfm_out_t   rec;
    bit          hit;
    logic [31:0] pos, v;
    logic [63:0] prod;
    logic [32:0] biased;
    int unsigned c, w, g;
    if (start) clear_parse();
    pos = file_pos;
    file_pos = file_pos + 1;
    rec = '0;
    hit = 0;
    case (phase)
      PhPre: begin
        if (b == CmdPre) phase = PhId;
        else begin
          rec.kind = KindBadPre; hit = 1; phase = PhDone;
        end
      end
      PhId: begin
        if (b == CmdId) phase = PhClen;
        else begin
          rec.kind = KindBadId; hit = 1; phase = PhDone;
        end
      end
      PhClen: begin
        skip_left = b;
        sub_item = 0;
        phase = (b != 0) ? PhCskip : PhHdr;
      end
      PhCskip: begin
        skip_left = skip_left - 1;
        if (skip_left == 0) phase = PhHdr;
      end
      PhHdr: begin
        accum = {accum[23:0], b};
        byte_cnt = byte_cnt + 1;
        if (byte_cnt == 3'd4) begin
          v = accum;
          accum = '0;
          byte_cnt = '0;
          if (sub_item < 3) begin
            fields[sub_item] = v;
            sub_item++;
          end else begin
            rec.kind = KindHeader;
            rec.tfm_width = fields[0];
            rec.escape_x = fields[2];
            rec.escape_y = v;
            rec.checksum_mismatch = dvi_chksum != 0 && fields[1] != 0 && dvi_chksum != fields[1];
            hit = 1;
            phase = PhSpec;
          end
        end
      end
      PhSpec: begin
        if (b < CmdXxx1) begin
          foreach (fields[i]) fields[i] = '0;
          form = (b[2:0] < 4) ? 2'd0 : ((b[2:0] < 7) ? 2'd1 : 2'd2);
          if (form == 2'd0) fields[0] = {22'd0, b[1:0], 8'd0};
          else if (form == 2'd1) fields[0] = {14'd0, b[1:0], 16'd0};
          pkt_start = pos;
          accum = '0;
          byte_cnt = '0;
          sub_item = 0;
          phase = PhChar;
        end else if (b <= CmdXxx4) begin
          form = 2'(b - CmdXxx1);
          accum = '0;
          byte_cnt = '0;
          phase = PhXlen;
        end else if (b == CmdYyy) begin
          skip_left = 4;
          phase = PhSkip;
        end else if (b == CmdPost) begin
          rec.kind = KindEnd; hit = 1; phase = PhDone;
        end else if (b != CmdNop) begin
          rec.kind = KindBadSpec; hit = 1; phase = PhDone;
        end
      end
      PhXlen: begin
        accum = {accum[23:0], b};
        byte_cnt = byte_cnt + 1;
        if (byte_cnt == 3'(form) + 3'd1) begin
          skip_left = accum;
          accum = '0;
          byte_cnt = '0;
          phase = (skip_left != 0) ? PhSkip : PhSpec;
        end
      end
      PhSkip: begin
        skip_left = skip_left - 1;
        if (skip_left == 0) phase = PhSpec;
      end
      PhChar: begin
        c = (form > 2) ? 2 : form;
        w = ItemBytes[c][sub_item];
        accum = {accum[23:0], b};
        byte_cnt = byte_cnt + 1;
        if (byte_cnt >= w) begin
          v = accum;
          accum = '0;
          byte_cnt = '0;
          if (ItemSigned[c][sub_item] && w < 4 && v[8*w-1]) v = v | (32'hFFFF_FFFF << (8*w));
          if (sub_item == 3 && c < 2) v = v << 16;
          if (sub_item == 0) v = v + fields[0];
          fields[sub_item] = v;
          if (sub_item == 1 && v >= CharCount) begin
            rec.kind = KindCharBig; hit = 1; phase = PhDone;
          end else begin
            g = sub_item + 1;
            while (g < 9 && ItemBytes[c][g] == 0) g++;
            if (g < 9) sub_item = g;
            else begin
              skip_left = (fields[0] > PreambleTail[c]) ? fields[0] - PreambleTail[c] : 0;
              prod = (64'(fields[2]) * 64'(scale_reg)) >> 20;
              biased = {1'b0, fields[3] ^ 32'h8000_0000} + 33'd32768;
              rec.kind = KindChar;
              rec.char_code = fields[1][7:0];
              rec.tfm_width = (prod > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : prod[31:0];
              rec.escape_x = fields[3];
              rec.escape_y = fields[4];
              rec.pixel_width = biased[31:16] ^ 16'h8000;
              rec.glyph_width = fields[5];
              rec.glyph_height = fields[6];
              rec.offset_x = fields[7];
              rec.offset_y = fields[8];
              rec.packet_offset = pkt_start;
              hit = 1;
              phase = (skip_left != 0) ? PhSkip : PhSpec;
            end
          end
        end
      end
      default: ;
    endcase
    if (hit) record_q.push_back(rec);
  endtask

  // Send one byte; hold it until the transfer, then maybe idle
  task automatic send_byte(input logic [7:0] b, input logic start);
    int unsigned gap;
    in_data <= '{data_byte: b, file_start: start};
    in_valid <= 1'b1;
    do @(posedge clk_i); while (in_stall);
    parse_byte(b, start);
    bytes_sent++;
    gap = 0;
    if ($urandom_range(0, 99) < gap_pct)
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 30) : $urandom_range(1, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_file();
    foreach (file_q[i]) send_byte(file_q[i], i == 0);
    file_q.delete();
  endtask

  task automatic push_be(input logic [31:0] v, input int unsigned n);
    for (int i = n - 1; i >= 0; i--) file_q.push_back(v[8*i +: 8]);
  endtask

  task automatic push_preamble(input logic [7:0] clen, input logic [31:0] chk);
    file_q.push_back(CmdPre);
    file_q.push_back(CmdId);
    file_q.push_back(clen);
    repeat (clen) file_q.push_back($urandom_range(0, 255));
    push_be($urandom, 4);
    push_be(chk, 4);
    push_be($urandom, 4);
    push_be($urandom, 4);
  endtask

  // Append one character packet; a short length leaves no raster
  task automatic push_char(input int unsigned f, input bit big_code, input bit short_len);
    logic [31:0] plen;
    int unsigned tail, raster;
    tail = PreambleTail[f];
    plen = short_len ? $urandom_range(0, tail - 1) : tail + $urandom_range(0, 3);
    raster = (plen > tail) ? plen - tail : 0;
    case (f)
      0: begin
        file_q.push_back({5'($urandom_range(0, 29)), 1'b0, plen[9:8]});
        file_q.push_back(plen[7:0]);
        push_be($urandom, 1);
        push_be($urandom, 3);
        repeat (5) push_be($urandom, 1);
      end
      1: begin
        file_q.push_back({5'($urandom_range(0, 29)), 1'b1, plen[17:16]});
        push_be(plen, 2);
        push_be($urandom, 1);
        push_be($urandom, 3);
        repeat (5) push_be($urandom, 2);
      end
      default: begin
        file_q.push_back({5'($urandom_range(0, 29)), 3'b111});
        push_be(plen, 4);
        push_be(big_code ? (($urandom_range(0, 1) != 0) ? 32'd256 : $urandom | 32'h100)
                         : $urandom_range(0, 255), 4);
        repeat (7) push_be($urandom, 4);
      end
    endcase
    repeat (raster) file_q.push_back($urandom_range(0, 255));
  endtask

  task automatic push_special();
    int unsigned n, len;
    case ($urandom_range(0, 2))
      0: begin
        n = $urandom_range(1, 4);
        len = $urandom_range(0, 5);
        file_q.push_back(CmdXxx1 + n - 1);
        push_be(len, n);
        repeat (len) file_q.push_back($urandom_range(0, 255));
      end
      1: begin
        file_q.push_back(CmdYyy);
        push_be($urandom, 4);
      end
      default: file_q.push_back(CmdNop);
    endcase
  endtask

  // Build one random file: mostly well formed, some broken or pure noise
  task automatic build_random_file();
    int unsigned sel, idx;
    logic [31:0] chk;
    sel = $urandom_range(0, 99);
    if (sel < 6) begin
      repeat ($urandom_range(1, 8)) file_q.push_back($urandom_range(0, 255));
      return;
    end
    case ($urandom_range(0, 3))
      0: chk = 0;
      1: chk = $urandom;
      default: chk = dvi_chksum;
    endcase
    push_preamble(($urandom_range(0, 19) == 0) ? 8'($urandom_range(7, 40))
                                               : 8'($urandom_range(0, 4)), chk);
    repeat ($urandom_range(1, 8)) begin
      if ($urandom_range(0, 3) == 0) push_special();
      else push_char($urandom_range(0, 2), $urandom_range(0, 29) == 0,
                     $urandom_range(0, 14) == 0);
    end
    sel = $urandom_range(0, 9);
    if (sel < 7) file_q.push_back(CmdPost);
    else if (sel == 7) file_q.push_back($urandom_range(CmdPre, 255));
    repeat ($urandom_range(0, 3)) file_q.push_back($urandom_range(0, 255));
    // Corrupt a byte now and then
    if ($urandom_range(0, 9) == 0) begin
      idx = $urandom_range(0, file_q.size() - 1);
      file_q[idx] = $urandom_range(0, 255);
    end
  endtask

  // Let every record drain, then allow the pipeline to settle
  task automatic drain();
    while (record_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic idx, input logic [31:0] v);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (idx == CfgFontScale) scale_reg = v;
    else dvi_chksum = v;
  endtask

  task automatic test_directed();
    gap_pct = 0;
    stall_pct = 0;
    write_cfg(CfgFontScale, 32'h0010_0000);
    write_cfg(CfgExpChksum, 32'h1234_5678);
    // Bad pre, then bytes ignored until a new file
    file_q = '{8'h00, CmdPre, CmdId};
    send_file();
    // Bad id
    file_q = '{CmdPre, 8'hFF};
    send_file();
    // Header with a mismatched checksum, every special, each preamble, post
    push_preamble(8'd2, 32'h1234_5679);
    file_q.push_back(CmdNop);
    file_q.push_back(CmdYyy);
    push_be(32'hFFFF_FFFF, 4);
    file_q.push_back(CmdXxx4);
    push_be(32'd1, 4);
    file_q.push_back(8'hAA);
    push_char(0, 0, 0);
    push_char(1, 0, 0);
    push_char(2, 0, 1);
    file_q.push_back(CmdPost);
    file_q.push_back(8'h55);
    send_file();
    // Code too big, and a bad special; restart in the middle of a file
    push_preamble(8'd0, 32'h1234_5678);
    push_char(2, 1, 0);
    send_file();
    push_preamble(8'd0, 32'd0);
    file_q.push_back(8'hFF);
    send_file();
    push_preamble(8'd1, 32'd7);
    send_file();
    in_valid <= 1'b0;
    drain();
  endtask

  task automatic run_random(input int unsigned target);
    int unsigned stop_at;
    stop_at = bytes_sent + target;
    while (bytes_sent < stop_at) begin
      // Alternate between quiet stretches and busy handshakes
      gap_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
      stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
      build_random_file();
      send_file();
    end
    in_valid <= 1'b0;
    drain();
  endtask

  task automatic test_config_sweep();
    write_cfg(CfgFontScale, 32'd0);
    write_cfg(CfgExpChksum, 32'd0);
    run_random(400);
    write_cfg(CfgFontScale, 32'hFFFF_FFFF);
    write_cfg(CfgExpChksum, 32'hFFFF_FFFF);
    run_random(400);
    write_cfg(CfgFontScale, 32'h0010_0000);
    write_cfg(CfgExpChksum, $urandom);
    run_random(400);
    repeat (2) begin
      write_cfg(CfgFontScale, $urandom);
      write_cfg(CfgExpChksum, $urandom);
      run_random(400);
    end
  endtask

  initial begin
    errors = 0;
    bytes_sent = 0;
    records_seen = 0;
    cycles = 0;
    stall_left = 0;
    gap_pct = 0;
    stall_pct = 0;
    scale_reg = '0;
    dvi_chksum = '0;
    clear_parse();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_config_sweep();
    $display("covered %0d bytes over headers, specials, all preamble forms and errors;",
             bytes_sent);
    $display("checked %0d records across five register settings", records_seen);
    if (errors == 0) $display("[pk_font_metrics_parser_top] OK");
    else $display("[pk_font_metrics_parser_top] ERROR");
    $finish;
  end

endmodule
